>>> hw/rtl/fak_pkg.sv
`default_nettype none
package fak_pkg;

   // config register indexes
   localparam int CSR_IDX_W = 3;
   localparam logic [CSR_IDX_W-1:0] CSR_SPACING_X  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SPACING_Y  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_SPACING_Z  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_SPREAD     = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_OBJ_MEAN   = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_DARK_OBJ   = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_TOP_LEVEL  = 3'd6;

   localparam int CFG_W   = 16;
   localparam int KAPPA_W = 16;
   localparam int STEP_W  = 2;

   // 2*spread^2 fits 33 bits
   localparam int DEN_W  = 33;
   // exponent t is unsigned q4.16
   localparam int T_W    = 20;
   // 20*norm and 20*norm+d2
   localparam int N20_W  = 38;
   localparam int ADEN_W = 39;
   localparam int ADJ_W  = 17;
   // exp accumulator q30, at most 1.0
   localparam int ACC_W  = 31;
   localparam int TAB_W  = 30;
   localparam int E_W    = 17;

   // exp(-2^(i-16)) in q30
   function automatic logic [TAB_W-1:0] exp_factor(input logic [4:0] idx);
      logic [TAB_W-1:0] v;
      case (idx)
         5'd0:  v = 30'd1073725440;
         5'd1:  v = 30'd1073709056;
         5'd2:  v = 30'd1073676290;
         5'd3:  v = 30'd1073610760;
         5'd4:  v = 30'd1073479712;
         5'd5:  v = 30'd1073217664;
         5'd6:  v = 30'd1072693760;
         5'd7:  v = 30'd1071646719;
         5'd8:  v = 30'd1069555701;
         5'd9:  v = 30'd1065385899;
         5'd10: v = 30'd1057095000;
         5'd11: v = 30'd1040706261;
         5'd12: v = 30'd1008687096;
         5'd13: v = 30'd947573834;
         5'd14: v = 30'd836230973;
         5'd15: v = 30'd651257337;
         5'd16: v = 30'd395007542;
         5'd17: v = 30'd145315154;
         5'd18: v = 30'd19666267;
         5'd19: v = 30'd360200;
         default: v = '0;
      endcase
      return v;
   endfunction

endpackage
`default_nettype wire

>>> hw/rtl/fak_div.sv
`default_nettype none
// restoring divider, one quotient bit per stage, num must be below den << Q_W
module fak_div #(
   parameter int DEN_W = 33,
   parameter int Q_W   = 20
) (
   input  wire logic                   clock,
   input  wire logic [DEN_W+Q_W-1:0]   num,
   input  wire logic [DEN_W-1:0]       den,
   output logic      [Q_W-1:0]         quo
);
   localparam int R_W = DEN_W + Q_W;

   logic [R_W-1:0]   rem_ff [Q_W];
   logic [DEN_W-1:0] den_ff [Q_W];
   logic [Q_W-1:0]   quo_ff [Q_W];

   for (genvar j = 0; j < Q_W; j++) begin : g_stage
      logic [R_W-1:0]   rem_prev;
      logic [DEN_W-1:0] den_prev;
      logic [Q_W-1:0]   quo_prev;
      logic [R_W-1:0]   shifted;
      logic             ge;
      logic [R_W-1:0]   rem_in;
      logic [Q_W-1:0]   quo_in;

      if (j == 0) begin : g_first
         assign rem_prev = num;
         assign den_prev = den;
         assign quo_prev = '0;
      end else begin : g_next
         assign rem_prev = rem_ff[j-1];
         assign den_prev = den_ff[j-1];
         assign quo_prev = quo_ff[j-1];
      end

      assign shifted = R_W'(den_prev) << (Q_W - 1 - j);
      assign ge      = (rem_prev >= shifted);
      assign rem_in  = ge ? (rem_prev - shifted) : rem_prev;
      assign quo_in  = ge ? (quo_prev | (Q_W'(1) << (Q_W - 1 - j))) : quo_prev;

      always_ff @(posedge clock) begin
         rem_ff[j] <= rem_in;
         den_ff[j] <= den_prev;
         quo_ff[j] <= quo_in;
      end
   end

   assign quo = quo_ff[Q_W-1];
endmodule
`default_nettype wire

>>> hw/rtl/fuzzy_affinity_kappa_unit.sv
`default_nettype none
// fuzzy connectedness affinity, quantized to a kappa level. one voxel pair is
// taken per clock (busy never rises) and its kappa appears on rsp_kappa with
// rsp_strobe high for one cycle, after passing stages 1 to 3, the two 20-stage
// restoring dividers (exponent and adjacency, side by side), the 20-stage exp
// product chain and the final product and kappa registers; there is no
// backpressure, so the receiver must take every result beat as it comes. config
// writes are always ready and are meant to happen while no pair is in flight;
// derived spacing and spread terms are registered from the config registers.
module fuzzy_affinity_kappa_unit #(
   parameter int INTENSITY_BITS = 16
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               start,
   output logic                                    busy,
   input  wire logic signed [INTENSITY_BITS-1:0]   req_center_value,
   input  wire logic signed [INTENSITY_BITS-1:0]   req_neighbor_value,
   input  wire logic signed [fak_pkg::STEP_W-1:0]  req_step_x,
   input  wire logic signed [fak_pkg::STEP_W-1:0]  req_step_y,
   input  wire logic signed [fak_pkg::STEP_W-1:0]  req_step_z,
   input  wire logic                               req_neighbor_inside,
   output logic                                    rsp_strobe,
   output logic [fak_pkg::KAPPA_W-1:0]             rsp_kappa,
   input  wire logic                               csr_valid,
   output logic                                    csr_ready,
   input  wire logic [fak_pkg::CSR_IDX_W-1:0]      csr_index,
   input  wire logic [fak_pkg::CFG_W-1:0]          csr_wdata
);
   import fak_pkg::*;

   // magnitude width covers q-p and q-mean
   localparam int MW = ((INTENSITY_BITS > CFG_W) ? INTENSITY_BITS : CFG_W) + 1;
   localparam int SQ_W = 2 * MW;
   localparam int S_W  = SQ_W + 1;
   localparam int CW   = (S_W > DEN_W + 4) ? S_W : DEN_W + 4;

   // ---------------------------------------------------------------- config
   logic [CFG_W-1:0]        spacing_x_ff, spacing_y_ff, spacing_z_ff;
   logic [CFG_W-1:0]        spread_ff, top_level_ff;
   logic signed [CFG_W-1:0] obj_mean_ff;
   logic                    dark_obj_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         spacing_x_ff <= 16'd256;
         spacing_y_ff <= 16'd256;
         spacing_z_ff <= 16'd256;
         spread_ff    <= 16'd100;
         obj_mean_ff  <= '0;
         dark_obj_ff  <= 1'b0;
         top_level_ff <= 16'd4095;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_SPACING_X: spacing_x_ff <= csr_wdata;
            CSR_SPACING_Y: spacing_y_ff <= csr_wdata;
            CSR_SPACING_Z: spacing_z_ff <= csr_wdata;
            CSR_SPREAD:    spread_ff    <= csr_wdata;
            CSR_OBJ_MEAN:  obj_mean_ff  <= csr_wdata;
            CSR_DARK_OBJ:  dark_obj_ff  <= csr_wdata[0];
            CSR_TOP_LEVEL: top_level_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // derived terms, zero registers read as one
   logic [CFG_W-1:0]   nz_x, nz_y, nz_z, nz_sg;
   logic [2*CFG_W-1:0] sq_x_ff, sq_y_ff, sq_z_ff, sg_sq_ff;
   logic [N20_W-1:0]   n20_ff;
   logic [N20_W-1:0]   norm_ext;
   logic [DEN_W-1:0]   den;

   assign nz_x  = (spacing_x_ff == '0) ? CFG_W'(1) : spacing_x_ff;
   assign nz_y  = (spacing_y_ff == '0) ? CFG_W'(1) : spacing_y_ff;
   assign nz_z  = (spacing_z_ff == '0) ? CFG_W'(1) : spacing_z_ff;
   assign nz_sg = (spread_ff == '0) ? CFG_W'(1) : spread_ff;

   assign norm_ext = N20_W'(sq_x_ff) + N20_W'(sq_y_ff) + N20_W'(sq_z_ff);
   assign den      = {sg_sq_ff, 1'b0};

   always_ff @(posedge clock) begin
      sq_x_ff  <= (2*CFG_W)'(nz_x) * (2*CFG_W)'(nz_x);
      sq_y_ff  <= (2*CFG_W)'(nz_y) * (2*CFG_W)'(nz_y);
      sq_z_ff  <= (2*CFG_W)'(nz_z) * (2*CFG_W)'(nz_z);
      sg_sq_ff <= (2*CFG_W)'(nz_sg) * (2*CFG_W)'(nz_sg);
      // 20 * norm as shift-add
      n20_ff   <= (norm_ext << 4) + (norm_ext << 2);
   end

   assign busy = 1'b0;

   // ---------------------------------------------------------------- stage 1
   // differences and the non-object side test
   logic signed [MW-1:0] dpq, dqm;
   logic                 second;
   logic [MW-1:0]        abs1_ff, abs2_ff;
   logic                 second_ff, inside1_ff, v1_ff;
   logic [2:0]           step_nz1_ff;

   assign dpq = MW'(req_neighbor_value) - MW'(req_center_value);
   assign dqm = MW'(req_neighbor_value) - MW'(obj_mean_ff);
   assign second = dark_obj_ff ? (dqm >= 0) : (dqm <= 0);

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else begin
         v1_ff <= start && !busy;
      end
   end

   always_ff @(posedge clock) begin
      abs1_ff     <= dpq[MW-1] ? MW'(-dpq) : MW'(dpq);
      abs2_ff     <= dqm[MW-1] ? MW'(-dqm) : MW'(dqm);
      second_ff   <= second;
      inside1_ff  <= req_neighbor_inside;
      // any nonzero offset is one step
      step_nz1_ff <= {req_step_z != '0, req_step_y != '0, req_step_x != '0};
   end

   // ---------------------------------------------------------------- stage 2
   // squares and the adjacency distance
   logic [SQ_W-1:0]   sq1_ff, sq2_ff;
   logic [ADEN_W-1:0] d2_ff;
   logic              inside2_ff, v2_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
      end else begin
         v2_ff <= v1_ff;
      end
   end

   always_ff @(posedge clock) begin
      sq1_ff     <= SQ_W'(abs1_ff) * SQ_W'(abs1_ff);
      sq2_ff     <= second_ff ? SQ_W'(abs2_ff) * SQ_W'(abs2_ff) : '0;
      d2_ff      <= (step_nz1_ff[0] ? ADEN_W'(sq_x_ff) : '0)
                  + (step_nz1_ff[1] ? ADEN_W'(sq_y_ff) : '0)
                  + (step_nz1_ff[2] ? ADEN_W'(sq_z_ff) : '0);
      inside2_ff <= inside1_ff;
   end

   // ---------------------------------------------------------------- stage 3
   // exponent range check and divider operands
   logic [CW-1:0]          s_sum;
   logic                   big;
   logic [ADEN_W-1:0]      aden;
   logic [DEN_W+T_W-1:0]   t_num_ff;
   logic [DEN_W-1:0]       t_den_ff;
   logic [ADEN_W+T_W-1:0]  a_num_ff;
   logic [ADEN_W-1:0]      a_den_ff;
   logic                   zero3_ff, v3_ff;

   assign s_sum = CW'(sq1_ff) + CW'(sq2_ff);
   // integer part of t at 16 or more gives exp 0
   assign big   = (s_sum >= (CW'(den) << 4));
   assign aden  = ADEN_W'(n20_ff) + d2_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v3_ff <= 1'b0;
      end else begin
         v3_ff <= v2_ff;
      end
   end

   always_ff @(posedge clock) begin
      t_num_ff <= (DEN_W + T_W)'(s_sum[DEN_W+3:0]) << 16;
      t_den_ff <= den;
      // round half up of 20n * 2^16 / (20n + d2)
      a_num_ff <= ((ADEN_W + T_W)'(n20_ff) << 16) + (ADEN_W + T_W)'(aden >> 1);
      a_den_ff <= aden;
      zero3_ff <= big || !inside2_ff;
   end

   // ---------------------------------------------------------------- dividers
   logic [T_W-1:0] t_quo, a_quo;

   fak_div #(.DEN_W(DEN_W), .Q_W(T_W)) u_t_div (
      .clock (clock),
      .num   (t_num_ff),
      .den   (t_den_ff),
      .quo   (t_quo)
   );

   fak_div #(.DEN_W(ADEN_W), .Q_W(T_W)) u_adj_div (
      .clock (clock),
      .num   (a_num_ff),
      .den   (a_den_ff),
      .quo   (a_quo)
   );

   // control travels beside the divider stages
   logic vd_ff [T_W];
   logic zd_ff [T_W];

   for (genvar j = 0; j < T_W; j++) begin : g_dctl
      always_ff @(posedge clock) begin
         if (reset) begin
            vd_ff[j] <= 1'b0;
         end else begin
            vd_ff[j] <= (j == 0) ? v3_ff : vd_ff[(j == 0) ? 0 : j-1];
         end
      end
      always_ff @(posedge clock) begin
         zd_ff[j] <= (j == 0) ? zero3_ff : zd_ff[(j == 0) ? 0 : j-1];
      end
   end

   // ---------------------------------------------------------------- exp chain
   // one table factor per bit of t, bit 0 first, each product rounded to q30
   logic [ACC_W-1:0] acc_ff [T_W];
   logic [T_W-1:0]   t_ff   [T_W];
   logic [ADJ_W-1:0] adj_ff [T_W];
   logic             ve_ff  [T_W];
   logic             ze_ff  [T_W];

   for (genvar i = 0; i < T_W; i++) begin : g_exp
      logic [ACC_W-1:0]         acc_prev;
      logic [T_W-1:0]           t_prev;
      logic [ADJ_W-1:0]         adj_prev;
      logic                     v_prev, z_prev;
      logic [ACC_W+TAB_W-1:0]   prod;
      logic [ACC_W+TAB_W-1:0]   prod_rnd;
      logic [ACC_W-1:0]         acc_in;

      if (i == 0) begin : g_first
         assign acc_prev = ACC_W'(1) << 30;
         assign t_prev   = t_quo;
         assign adj_prev = a_quo[ADJ_W-1:0];
         assign v_prev   = vd_ff[T_W-1];
         assign z_prev   = zd_ff[T_W-1];
      end else begin : g_next
         assign acc_prev = acc_ff[i-1];
         assign t_prev   = t_ff[i-1];
         assign adj_prev = adj_ff[i-1];
         assign v_prev   = ve_ff[i-1];
         assign z_prev   = ze_ff[i-1];
      end

      assign prod     = (ACC_W + TAB_W)'(acc_prev) * (ACC_W + TAB_W)'(exp_factor(5'(i)));
      assign prod_rnd = (prod + ((ACC_W + TAB_W)'(1) << 29)) >> 30;
      assign acc_in   = t_prev[i] ? prod_rnd[ACC_W-1:0] : acc_prev;

      always_ff @(posedge clock) begin
         if (reset) begin
            ve_ff[i] <= 1'b0;
         end else begin
            ve_ff[i] <= v_prev;
         end
      end

      always_ff @(posedge clock) begin
         acc_ff[i] <= acc_in;
         t_ff[i]   <= t_prev;
         adj_ff[i] <= adj_prev;
         ze_ff[i]  <= z_prev;
      end
   end

   // ---------------------------------------------------------------- final
   // e in q16, then e * adj * top_level rounded back by 2^32
   logic [ACC_W-1:0]       acc_rnd;
   logic [E_W-1:0]         e_val;
   logic [E_W+ADJ_W-1:0]   ea_ff;
   logic                   zf_ff, vf_ff;
   logic [E_W+ADJ_W+CFG_W-1:0] full;
   logic [E_W+ADJ_W+CFG_W-1:0] full_rnd;
   logic [KAPPA_W-1:0]     kappa_ff;
   logic                   vo_ff;

   assign acc_rnd = acc_ff[T_W-1] + ACC_W'(1 << 13);
   assign e_val   = acc_rnd[ACC_W-1:14];

   always_ff @(posedge clock) begin
      if (reset) begin
         vf_ff <= 1'b0;
         vo_ff <= 1'b0;
      end else begin
         vf_ff <= ve_ff[T_W-1];
         vo_ff <= vf_ff;
      end
   end

   always_ff @(posedge clock) begin
      ea_ff <= (E_W + ADJ_W)'(e_val) * (E_W + ADJ_W)'(adj_ff[T_W-1]);
      zf_ff <= ze_ff[T_W-1];
   end

   assign full     = (E_W + ADJ_W + CFG_W)'(ea_ff) * (E_W + ADJ_W + CFG_W)'(top_level_ff);
   assign full_rnd = (full + ((E_W + ADJ_W + CFG_W)'(1) << 31)) >> 32;

   always_ff @(posedge clock) begin
      // outside neighbor or huge exponent gives level 0
      kappa_ff <= zf_ff ? '0 : full_rnd[KAPPA_W-1:0];
   end

   assign rsp_strobe = vo_ff;
   assign rsp_kappa  = kappa_ff;
endmodule
`default_nettype wire
